[rtl/pzvt_pkg.sv]
package pzvt_pkg;

  localparam int REV_W     = 32;
  localparam int CMD_W     = 3;
  localparam int OP_W      = 4;
  localparam int SLOT_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_S2W = 3'd0;
  localparam logic [CMD_W-1:0] CMD_W2S = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ZOOM = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_VIS = 3'd5;

  localparam logic [OP_W-1:0] OP_DIV_X_Z  = 4'd0;
  localparam logic [OP_W-1:0] OP_DIV_Y_Z  = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV_X_NZ = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_Y_NZ = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL_DX   = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL_DY   = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_UW   = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV_UH   = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV_PAD  = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_CW   = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV_CH   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ZOOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ZOOM = 2'd3;

  typedef struct packed {
    logic              load;
    logic              start;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic              commit;
  } dp_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fit_bad;
    logic             done;
  } dp_stat_t;

endpackage

[rtl/pzvt_if.sv]
interface pzvt_in_if #(
  parameter int COORD_WIDTH = 32,
  parameter int ZOOM_WIDTH  = 20
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    command;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] rect_width;
  logic signed [COORD_WIDTH-1:0] rect_height;
  logic signed [COORD_WIDTH-1:0] padding;
  logic [ZOOM_WIDTH-1:0]         zoom_request;

  modport source(output valid, command, in_x, in_y, rect_width, rect_height, padding,
                 zoom_request, input ready);
  modport sink(input valid, command, in_x, in_y, rect_width, rect_height, padding,
               zoom_request, output ready);
endinterface

interface pzvt_out_if #(
  parameter int COORD_WIDTH = 32,
  parameter int ZOOM_WIDTH  = 20
);
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic [COORD_WIDTH-1:0]        out_width;
  logic [COORD_WIDTH-1:0]        out_height;
  logic [ZOOM_WIDTH-1:0]         current_zoom;
  logic [31:0]                   revision;

  modport source(output valid, status, out_x, out_y, out_width, out_height, current_zoom,
                 revision, input ready);
  modport sink(input valid, status, out_x, out_y, out_width, out_height, current_zoom,
               revision, output ready);
endinterface

[rtl/pzvt_ctrl.sv]
module pzvt_ctrl import pzvt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ISSUE  = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              bypass;

  function automatic logic [OP_W-1:0] op_for(input logic [CMD_W-1:0] cmd,
                                             input logic [SLOT_W-1:0] step);
    logic [OP_W-1:0] op;
    op = OP_DIV_X_Z;
    case (cmd)
      CMD_S2W, CMD_PAN: op = (step == 2'd0) ? OP_DIV_X_Z : OP_DIV_Y_Z;
      CMD_W2S: op = (step == 2'd0) ? OP_MUL_DX : OP_MUL_DY;
      CMD_ZOOM: begin
        case (step)
          2'd0: op = OP_DIV_X_Z;
          2'd1: op = OP_DIV_X_NZ;
          2'd2: op = OP_DIV_Y_Z;
          default: op = OP_DIV_Y_NZ;
        endcase
      end
      CMD_FIT: begin
        case (step)
          2'd0: op = OP_DIV_UW;
          2'd1: op = OP_DIV_UH;
          default: op = OP_DIV_PAD;
        endcase
      end
      CMD_VIS: op = (step == 2'd0) ? OP_DIV_CW : OP_DIV_CH;
      default: op = OP_DIV_X_Z;
    endcase
    return op;
  endfunction

  function automatic logic [SLOT_W-1:0] last_step(input logic [CMD_W-1:0] cmd);
    logic [SLOT_W-1:0] s;
    case (cmd)
      CMD_ZOOM: s = 2'd3;
      CMD_FIT:  s = 2'd2;
      default:  s = 2'd1;
    endcase
    return s;
  endfunction

  assign bypass = (stat.cmd > CMD_VIS) || ((stat.cmd == CMD_FIT) && stat.fit_bad);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctl       = '0;
    ctl.op    = op_for(stat.cmd, step_r);
    ctl.slot  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (bypass) begin
          state_nxt = S_COMMIT;
        end else begin
          ctl.start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.done) begin
          if (step_r == last_step(stat.cmd)) begin
            state_nxt = S_COMMIT;
          end else begin
            step_nxt  = step_r + 2'd1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = ctl.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/pzvt_arith.sv]
module pzvt_arith #(
  parameter int COORD_WIDTH    = 32,
  parameter int ZOOM_FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic                                     is_mul,
  input  logic [COORD_WIDTH-1:0]                   num,
  input  logic [((COORD_WIDTH > ZOOM_FRAC_BITS + 4) ? COORD_WIDTH :
                 ZOOM_FRAC_BITS + 4)-1:0]           den,
  input  logic [((COORD_WIDTH > ZOOM_FRAC_BITS + 4) ? COORD_WIDTH :
                 ZOOM_FRAC_BITS + 4):0]             cap,
  output logic                                     done,
  output logic [((COORD_WIDTH > ZOOM_FRAC_BITS + 4) ? COORD_WIDTH :
                 ZOOM_FRAC_BITS + 4):0]             res
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = ZOOM_FRAC_BITS;
  localparam int ZW   = F + 4;
  localparam int DENW = (CW > ZW) ? CW : ZW;
  localparam int WW   = DENW + 1;
  localparam int QW   = CW + F;
  localparam int PW   = CW + ZW + 1;
  localparam int CNTW = $clog2(QW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            mul_r;
  logic [CNTW-1:0] cnt_r;
  logic [QW-1:0]   dq_r;
  logic [DENW-1:0] rem_r;
  logic [DENW-1:0] den_r;
  logic [CW-1:0]   m_r;
  logic [PW-1:0]   prod_r;
  logic [WW-1:0]   cap_r;
  logic [DENW:0]   rem_sh;
  logic            qbit;
  logic [CW:0]     psum;
  logic [QW-1:0]   qext;

  assign rem_sh = {rem_r, dq_r[QW-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});
  assign psum   = prod_r[PW-1:ZW] + (prod_r[0] ? {1'b0, m_r} : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r == CNTW'(1))) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mul_r  <= is_mul;
      cnt_r  <= is_mul ? CNTW'(ZW) : CNTW'(QW);
      dq_r   <= {num, {F{1'b0}}};
      rem_r  <= '0;
      den_r  <= den;
      m_r    <= num;
      prod_r <= {{(CW + 1){1'b0}}, den[ZW-1:0]};
      cap_r  <= cap;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (mul_r) begin
        prod_r <= {1'b0, psum, prod_r[ZW-1:1]};
      end else begin
        rem_r <= qbit ? DENW'(rem_sh - {1'b0, den_r}) : rem_sh[DENW-1:0];
        dq_r  <= {dq_r[QW-2:0], qbit};
      end
    end
  end

  assign qext = mul_r ? QW'(prod_r[CW+ZW-1:F]) : dq_r;
  assign res  = (qext > QW'(cap_r)) ? cap_r : qext[WW-1:0];
  assign done = done_r;

endmodule

[rtl/pzvt_dp.sv]
module pzvt_dp import pzvt_pkg::*; #(
  parameter int COORD_WIDTH    = 32,
  parameter int ZOOM_FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  dp_ctrl_t                                 ctl,
  output dp_stat_t                                 stat,
  input  logic [CMD_W-1:0]                         command,
  input  logic signed [COORD_WIDTH-1:0]            in_x,
  input  logic signed [COORD_WIDTH-1:0]            in_y,
  input  logic signed [COORD_WIDTH-1:0]            rect_width,
  input  logic signed [COORD_WIDTH-1:0]            rect_height,
  input  logic signed [COORD_WIDTH-1:0]            padding,
  input  logic [ZOOM_FRAC_BITS+3:0]                zoom_request,
  input  logic                                     cfg_we,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  logic [((COORD_WIDTH > ZOOM_FRAC_BITS + 4) ? COORD_WIDTH :
                 ZOOM_FRAC_BITS + 4)-1:0]           cfg_data,
  output logic                                     status,
  output logic signed [COORD_WIDTH-1:0]            out_x,
  output logic signed [COORD_WIDTH-1:0]            out_y,
  output logic [COORD_WIDTH-1:0]                   out_width,
  output logic [COORD_WIDTH-1:0]                   out_height,
  output logic [ZOOM_FRAC_BITS+3:0]                current_zoom,
  output logic [REV_W-1:0]                         revision
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = ZOOM_FRAC_BITS;
  localparam int ZW   = F + 4;
  localparam int DENW = (CW > ZW) ? CW : ZW;
  localparam int WW   = DENW + 1;
  localparam int SW   = CW + 2;

  localparam logic [WW-1:0] MAG_CAP   = {{(WW - CW){1'b0}}, 1'b1, {(CW - 1){1'b0}}};
  localparam logic [WW-1:0] COORD_CAP = {{(WW - CW){1'b0}}, {CW{1'b1}}};
  localparam logic [WW-1:0] ZOOM_CAP  = {{(WW - ZW){1'b0}}, {ZW{1'b1}}};
  localparam logic signed [SW-1:0] SMAX = {3'b000, {(CW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {3'b111, {(CW - 1){1'b0}}};
  localparam logic [ZW-1:0] ZOOM_ONE  = ZW'(1) << F;
  localparam logic [ZW-1:0] ZMIN_RST  = ZW'(((1 << F) + 5) / 10);
  localparam logic [ZW-1:0] ZMAX_RST  = ZW'(8) << F;
  localparam logic [CW-1:0] CANVAS_RST = CW'(1) << 16;

  // view state and registers
  logic signed [CW-1:0] ox_r, oy_r;
  logic [ZW-1:0]        zoom_r;
  logic [REV_W-1:0]     rev_r;
  logic [CW-1:0]        cw_r, ch_r;
  logic [ZW-1:0]        zmin_r, zmax_r;

  // latched item
  logic [CMD_W-1:0]     cmd_r;
  logic signed [CW-1:0] x_r, y_r, rw_r, rh_r, pad_r;
  logic [ZW-1:0]        zreq_r;

  logic [WW-1:0]        u_r [4];
  logic [SLOT_W-1:0]    slot_r;

  logic                 a_mul;
  logic [CW-1:0]        a_num;
  logic [DENW-1:0]      a_den;
  logic [WW-1:0]        a_cap;
  logic                 a_done;
  logic [WW-1:0]        a_res;

  logic signed [CW:0]   dx, dy;
  logic [CW:0]          dx_abs, dy_abs;
  logic [CW-1:0]        x_mag, y_mag;
  logic signed [CW+1:0] uw, uh;
  logic                 fit_bad;
  logic [ZW-1:0]        fit_min, nz;

  logic                 st_c;
  logic signed [CW-1:0] ox_c, oy_c, nox_c, noy_c;
  logic [CW-1:0]        ow_c, oh_c;
  logic [ZW-1:0]        nzoom_c;
  logic                 bump_c;

  function automatic logic signed [CW-1:0] satc(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SMAX) r = SMAX[CW-1:0];
    else if (v < SMIN) r = SMIN[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [SW-1:0] sext(input logic signed [CW-1:0] v);
    return {{2{v[CW-1]}}, v};
  endfunction

  // signed quotient or product, saturated
  function automatic logic signed [SW-1:0] sval(input logic [WW-1:0] u, input logic neg);
    logic signed [SW-1:0] uv;
    uv = $signed({2'b00, u[CW-1:0]});
    return sext(satc(neg ? -uv : uv));
  endfunction

  function automatic logic [ZW-1:0] clampz(input logic [ZW-1:0] z, input logic [ZW-1:0] lo,
                                           input logic [ZW-1:0] hi);
    logic [ZW-1:0] r;
    if (z < lo) r = lo;
    else if (z > hi) r = hi;
    else r = z;
    return (r == '0) ? ZW'(1) : r;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= command;
      x_r    <= in_x;
      y_r    <= in_y;
      rw_r   <= rect_width;
      rh_r   <= rect_height;
      pad_r  <= padding;
      zreq_r <= zoom_request;
    end
    if (ctl.start) slot_r <= ctl.slot;
    if (a_done) u_r[slot_r] <= a_res;
  end

  assign x_mag  = x_r[CW-1] ? -x_r : x_r;
  assign y_mag  = y_r[CW-1] ? -y_r : y_r;
  assign dx     = {x_r[CW-1], x_r} - {ox_r[CW-1], ox_r};
  assign dy     = {y_r[CW-1], y_r} - {oy_r[CW-1], oy_r};
  assign dx_abs = dx[CW] ? -dx : dx;
  assign dy_abs = dy[CW] ? -dy : dy;
  assign uw     = $signed({2'b00, cw_r}) - $signed({1'b0, pad_r, 1'b0});
  assign uh     = $signed({2'b00, ch_r}) - $signed({1'b0, pad_r, 1'b0});
  assign fit_bad = (rw_r <= 0) || (rh_r <= 0) || pad_r[CW-1] || (uw <= 0) || (uh <= 0);
  assign fit_min = (u_r[0] < u_r[1]) ? u_r[0][ZW-1:0] : u_r[1][ZW-1:0];
  assign nz = (cmd_r == CMD_FIT) ? clampz(fit_min, zmin_r, zmax_r)
                                 : clampz(zreq_r, zmin_r, zmax_r);

  always_comb begin
    a_mul = 1'b0;
    a_num = x_mag;
    a_den = DENW'(zoom_r);
    a_cap = MAG_CAP;
    case (ctl.op)
      OP_DIV_X_Z:  a_num = x_mag;
      OP_DIV_Y_Z:  a_num = y_mag;
      OP_DIV_X_NZ: a_den = DENW'(nz);
      OP_DIV_Y_NZ: begin
        a_num = y_mag;
        a_den = DENW'(nz);
      end
      OP_MUL_DX: begin
        a_mul = 1'b1;
        a_num = dx_abs[CW-1:0];
      end
      OP_MUL_DY: begin
        a_mul = 1'b1;
        a_num = dy_abs[CW-1:0];
      end
      OP_DIV_UW: begin
        a_num = uw[CW-1:0];
        a_den = DENW'($unsigned(rw_r));
        a_cap = ZOOM_CAP;
      end
      OP_DIV_UH: begin
        a_num = uh[CW-1:0];
        a_den = DENW'($unsigned(rh_r));
        a_cap = ZOOM_CAP;
      end
      OP_DIV_PAD: begin
        a_num = pad_r;
        a_den = DENW'(nz);
      end
      OP_DIV_CW: begin
        a_num = cw_r;
        a_cap = COORD_CAP;
      end
      OP_DIV_CH: begin
        a_num = ch_r;
        a_cap = COORD_CAP;
      end
      default: a_num = x_mag;
    endcase
  end

  pzvt_arith #(
    .COORD_WIDTH   (COORD_WIDTH),
    .ZOOM_FRAC_BITS(ZOOM_FRAC_BITS)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.start),
    .is_mul(a_mul),
    .num   (a_num),
    .den   (a_den),
    .cap   (a_cap),
    .done  (a_done),
    .res   (a_res)
  );

  always_comb begin
    st_c    = 1'b0;
    ox_c    = '0;
    oy_c    = '0;
    ow_c    = '0;
    oh_c    = '0;
    nox_c   = ox_r;
    noy_c   = oy_r;
    nzoom_c = zoom_r;
    bump_c  = 1'b0;
    case (cmd_r)
      CMD_S2W: begin
        ox_c = satc(sext(ox_r) + sval(u_r[0], x_r[CW-1]));
        oy_c = satc(sext(oy_r) + sval(u_r[1], y_r[CW-1]));
      end
      CMD_W2S: begin
        ox_c = satc(sval(u_r[0], dx[CW]));
        oy_c = satc(sval(u_r[1], dy[CW]));
      end
      CMD_ZOOM: begin
        nzoom_c = nz;
        nox_c = satc(sext(ox_r) + sval(u_r[0], x_r[CW-1]) - sval(u_r[1], x_r[CW-1]));
        noy_c = satc(sext(oy_r) + sval(u_r[2], y_r[CW-1]) - sval(u_r[3], y_r[CW-1]));
        bump_c = 1'b1;
      end
      CMD_PAN: begin
        nox_c  = satc(sext(ox_r) - sval(u_r[0], x_r[CW-1]));
        noy_c  = satc(sext(oy_r) - sval(u_r[1], y_r[CW-1]));
        bump_c = 1'b1;
      end
      CMD_FIT: begin
        if (fit_bad) begin
          st_c = 1'b1;
        end else begin
          nzoom_c = nz;
          nox_c   = satc(sext(x_r) - sval(u_r[2], 1'b0));
          noy_c   = satc(sext(y_r) - sval(u_r[2], 1'b0));
          bump_c  = 1'b1;
        end
      end
      CMD_VIS: begin
        ox_c = ox_r;
        oy_c = oy_r;
        ow_c = u_r[0][CW-1:0];
        oh_c = u_r[1][CW-1:0];
      end
      default: st_c = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r   <= '0;
      oy_r   <= '0;
      zoom_r <= ZOOM_ONE;
      rev_r  <= REV_W'(1);
      cw_r   <= CANVAS_RST;
      ch_r   <= CANVAS_RST;
      zmin_r <= ZMIN_RST;
      zmax_r <= ZMAX_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CANVAS_W: cw_r   <= cfg_data[CW-1:0];
          CFG_CANVAS_H: ch_r   <= cfg_data[CW-1:0];
          CFG_MIN_ZOOM: zmin_r <= cfg_data[ZW-1:0];
          CFG_MAX_ZOOM: zmax_r <= cfg_data[ZW-1:0];
          default: ;
        endcase
      end
      if (ctl.commit) begin
        ox_r   <= nox_c;
        oy_r   <= noy_c;
        zoom_r <= nzoom_c;
        if (bump_c) rev_r <= rev_r + REV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status       <= st_c;
      out_x        <= ox_c;
      out_y        <= oy_c;
      out_width    <= ow_c;
      out_height   <= oh_c;
      current_zoom <= nzoom_c;
      revision     <= bump_c ? rev_r + REV_W'(1) : rev_r;
    end
  end

  assign stat.cmd     = cmd_r;
  assign stat.fit_bad = fit_bad;
  assign stat.done    = a_done;

endmodule

[rtl/pan_zoom_viewport_transform.sv]
// Pan and zoom viewport transform.
// in_ch carries one command item (screen/world mapping, set zoom around an
// anchor, pan, fit rectangle, visible rectangle); out_ch returns exactly one
// result item per command with status, mapped point or visible rectangle,
// the zoom and the revision count after the command.
// cfg_we/cfg_index/cfg_data write canvas width, canvas height, min zoom and
// max zoom; write them only while no command is in flight.
// One shared radix-2 unit does all divisions and multiplications. An item is
// loaded on accept, then runs k unit operations in turn, each issued and then
// awaited, and is then committed to the output: k is 2 for mapping, pan and
// visible rectangle, 3 for fit, 4 for set zoom; invalid commands and rejected
// fits run none and go straight to commit. One item is worked on at a time.
// A new item is accepted while the previous result still waits in the output
// register; if the receiver stalls, the block holds the finished result and
// the next item waits before its update until out_ch is free.
// Reset (rst_n low, synchronous) restores origin 0, zoom 1.0, revision 1 and
// the default register values.
module pan_zoom_viewport_transform import pzvt_pkg::*; #(
  parameter int COORD_WIDTH    = 32,
  parameter int ZOOM_FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  pzvt_in_if.sink                                  in_ch,
  pzvt_out_if.source                               out_ch,
  input  logic                                     cfg_we,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  logic [((COORD_WIDTH > ZOOM_FRAC_BITS + 4) ? COORD_WIDTH :
                 ZOOM_FRAC_BITS + 4)-1:0]           cfg_data
);

  dp_ctrl_t ctl;
  dp_stat_t stat;

  pzvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  pzvt_dp #(
    .COORD_WIDTH   (COORD_WIDTH),
    .ZOOM_FRAC_BITS(ZOOM_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .command     (in_ch.command),
    .in_x        (in_ch.in_x),
    .in_y        (in_ch.in_y),
    .rect_width  (in_ch.rect_width),
    .rect_height (in_ch.rect_height),
    .padding     (in_ch.padding),
    .zoom_request(in_ch.zoom_request),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (out_ch.status),
    .out_x       (out_ch.out_x),
    .out_y       (out_ch.out_y),
    .out_width   (out_ch.out_width),
    .out_height  (out_ch.out_height),
    .current_zoom(out_ch.current_zoom),
    .revision    (out_ch.revision)
  );

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("result committed over an unread result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item accepted while one is in flight");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctl.commit))
    else $error("result shown without a commit");

  a_no_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !in_ch.ready)
    else $error("arithmetic started with no item");

endmodule

[tb/sv/pan_zoom_viewport_transform_tb.sv]
module pan_zoom_viewport_transform_tb import pzvt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;
  localparam longint unsigned MAG_LIMIT = 64'd2147483648;
  localparam longint unsigned ZOOM_LIMIT = 64'd1048575;
  localparam longint unsigned SIZE_LIMIT = 64'd4294967295;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] rw;
    logic signed [31:0] rh;
    logic signed [31:0] pad;
    logic [19:0]        zreq;
  } view_cmd_t;

  typedef struct {
    logic               status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        w;
    logic [31:0]        h;
    logic [19:0]        zoom;
    logic [31:0]        rev;
  } view_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pzvt_in_if  in_ch();
  pzvt_out_if out_ch();

  pan_zoom_viewport_transform dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // view model state
  longint view_origin_x, view_origin_y;
  longint unsigned view_zoom, canvas_w, canvas_h, zoom_lo, zoom_hi;
  bit [31:0] view_rev;

  view_result_t expected_views[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint clip_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den,
                                               longint unsigned cap);
    longint unsigned q, r;
    if (den == 0) return cap;
    q = num / den;
    if (q > (cap >> 16)) return cap;
    r = num % den;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return (q > cap) ? cap : q;
  endfunction

  function automatic longint unsigned frac_mul(longint unsigned m, longint unsigned z,
                                               longint unsigned cap);
    longint unsigned hi, lo, r;
    hi = m >> 16;
    lo = m & 64'hFFFF;
    if (z == 0) return 0;
    if (hi != 0 && hi > cap / z) return cap;
    r = hi * z + ((lo * z) >> 16);
    return (r > cap) ? cap : r;
  endfunction

  function automatic longint unsigned magnitude(longint a);
    return (a < 0) ? longint'(0) - a : a;
  endfunction

  function automatic longint div_by_zoom(longint a, longint unsigned z);
    longint r;
    r = longint'(frac_div(magnitude(a), z, MAG_LIMIT));
    return clip_coord(a < 0 ? -r : r);
  endfunction

  function automatic longint mul_by_zoom(longint a, longint unsigned z);
    longint r;
    r = longint'(frac_mul(magnitude(a), z, MAG_LIMIT));
    return clip_coord(a < 0 ? -r : r);
  endfunction

  function automatic longint unsigned clamp_zoom(longint unsigned z);
    if (z < zoom_lo) z = zoom_lo;
    else if (z > zoom_hi) z = zoom_hi;
    return (z == 0) ? 1 : z;
  endfunction

  function automatic view_result_t predict_view(view_cmd_t c);
    view_result_t r;
    longint x, y, rw, rh, pad, uw, uh, dx, dy;
    longint unsigned zx, zy, nz;
    x = c.x; y = c.y; rw = c.rw; rh = c.rh; pad = c.pad;
    r.status = 1'b0;
    r.x = '0; r.y = '0; r.w = '0; r.h = '0;
    case (c.cmd)
      CMD_S2W: begin
        r.x = 32'(clip_coord(view_origin_x + div_by_zoom(x, view_zoom)));
        r.y = 32'(clip_coord(view_origin_y + div_by_zoom(y, view_zoom)));
      end
      CMD_W2S: begin
        r.x = 32'(mul_by_zoom(x - view_origin_x, view_zoom));
        r.y = 32'(mul_by_zoom(y - view_origin_y, view_zoom));
      end
      CMD_ZOOM: begin
        nz = clamp_zoom(c.zreq);
        dx = div_by_zoom(x, view_zoom) - div_by_zoom(x, nz);
        dy = div_by_zoom(y, view_zoom) - div_by_zoom(y, nz);
        view_zoom = nz;
        view_origin_x = clip_coord(view_origin_x + dx);
        view_origin_y = clip_coord(view_origin_y + dy);
        view_rev++;
      end
      CMD_PAN: begin
        view_origin_x = clip_coord(view_origin_x - div_by_zoom(x, view_zoom));
        view_origin_y = clip_coord(view_origin_y - div_by_zoom(y, view_zoom));
        view_rev++;
      end
      CMD_FIT: begin
        uw = longint'(canvas_w) - 2 * pad;
        uh = longint'(canvas_h) - 2 * pad;
        if (rw <= 0 || rh <= 0 || pad < 0 || uw <= 0 || uh <= 0) begin
          r.status = 1'b1;
        end else begin
          zx = frac_div(uw, rw, ZOOM_LIMIT);
          zy = frac_div(uh, rh, ZOOM_LIMIT);
          nz = clamp_zoom(zx < zy ? zx : zy);
          view_zoom = nz;
          view_origin_x = clip_coord(x - div_by_zoom(pad, nz));
          view_origin_y = clip_coord(y - div_by_zoom(pad, nz));
          view_rev++;
        end
      end
      CMD_VIS: begin
        r.x = 32'(view_origin_x);
        r.y = 32'(view_origin_y);
        r.w = 32'(frac_div(canvas_w, view_zoom, SIZE_LIMIT));
        r.h = 32'(frac_div(canvas_h, view_zoom, SIZE_LIMIT));
      end
      default: r.status = 1'b1;
    endcase
    r.zoom = 20'(view_zoom);
    r.rev = view_rev;
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    view_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_views.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_ch.out_x, out_ch.out_y);
      end else begin
        e = expected_views.pop_front();
        if (out_ch.status !== e.status || out_ch.out_x !== e.x || out_ch.out_y !== e.y ||
            out_ch.out_width !== e.w || out_ch.out_height !== e.h ||
            out_ch.current_zoom !== e.zoom || out_ch.revision !== e.rev) begin
          errors++;
          $display("%0t: expected st=%0d x=%0d y=%0d w=%0d h=%0d z=%0d rev=%0d", $time,
                   e.status, e.x, e.y, e.w, e.h, e.zoom, e.rev);
          $display("%0t: actual   st=%0d x=%0d y=%0d w=%0d h=%0d z=%0d rev=%0d", $time,
                   out_ch.status, out_ch.out_x, out_ch.out_y, out_ch.out_width,
                   out_ch.out_height, out_ch.current_zoom, out_ch.revision);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(view_cmd_t c);
    in_ch.valid        <= 1'b1;
    in_ch.command      <= c.cmd;
    in_ch.in_x         <= c.x;
    in_ch.in_y         <= c.y;
    in_ch.rect_width   <= c.rw;
    in_ch.rect_height  <= c.rh;
    in_ch.padding      <= c.pad;
    in_ch.zoom_request <= c.zreq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_views.push_back(predict_view(c));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_CANVAS_W: canvas_w = val;
      CFG_CANVAS_H: canvas_h = val;
      CFG_MIN_ZOOM: zoom_lo = val[19:0];
      default:      zoom_hi = val[19:0];
    endcase
  endtask

  task automatic set_view_regs(logic [31:0] cw, logic [31:0] ch, logic [19:0] zl,
                               logic [19:0] zh);
    drain();
    write_reg(CFG_CANVAS_W, cw);
    write_reg(CFG_CANVAS_H, ch);
    write_reg(CFG_MIN_ZOOM, 32'(zl));
    write_reg(CFG_MAX_ZOOM, 32'(zh));
    cfg_we <= 1'b0;
  endtask

  function automatic view_cmd_t make_cmd(logic [2:0] cmd, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] rw,
                                         logic signed [31:0] rh, logic signed [31:0] pad,
                                         logic [19:0] zreq);
    view_cmd_t c;
    c.cmd = cmd; c.x = x; c.y = y; c.rw = rw; c.rh = rh; c.pad = pad; c.zreq = zreq;
    return c;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      3: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
      default: return ($signed($urandom_range(0, 2000)) - 1000) <<< 16;
    endcase
  endfunction

  function automatic view_cmd_t rand_cmd();
    view_cmd_t c;
    int pick;
    c = make_cmd(3'd0, rand_coord(), rand_coord(), $urandom, $urandom, $urandom,
                 20'($urandom_range(0, 20'hFFFFF)));
    pick = $urandom_range(0, 99);
    if (pick < 18) c.cmd = CMD_S2W;
    else if (pick < 36) c.cmd = CMD_W2S;
    else if (pick < 54) c.cmd = CMD_ZOOM;
    else if (pick < 68) c.cmd = CMD_PAN;
    else if (pick < 86) c.cmd = CMD_FIT;
    else if (pick < 96) c.cmd = CMD_VIS;
    else c.cmd = pick[0] ? CMD_BAD6 : CMD_BAD7;
    if (c.cmd == CMD_ZOOM && $urandom_range(0, 2) != 0)
      c.zreq = 20'($urandom_range(32'(zoom_lo > 4 ? zoom_lo - 4 : 0), 32'(zoom_hi + 4)));
    if (c.cmd == CMD_FIT && $urandom_range(0, 4) != 0) begin
      c.rw  = $urandom_range(1, 32'h0FFFFFF);
      c.rh  = $urandom_range(1, 32'h0FFFFFF);
      c.pad = $urandom_range(0, 32'(canvas_w > 8 ? canvas_w / 8 : 1));
    end
    return c;
  endfunction

  task automatic run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_cmd(rand_cmd());
      if (i == n / 2 && idle > 0) drain();
    end
  endtask

  task automatic test_directed;
    send_cmd(make_cmd(CMD_VIS, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_S2W, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_W2S, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 0));
    // zoom clamps to min, max and full-scale request
    send_cmd(make_cmd(CMD_ZOOM, 32'sh00100000, -32'sh00100000, 0, 0, 0, 20'd0));
    send_cmd(make_cmd(CMD_S2W, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ZOOM, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 20'hFFFFF));
    send_cmd(make_cmd(CMD_W2S, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ZOOM, 0, 0, 0, 0, 0, 20'h10000));
    send_cmd(make_cmd(CMD_PAN, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_PAN, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_VIS, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_FIT, 32'sh10000, -32'sh10000, 32'sh20000, 32'sh10000, 32'sh1000, 0));
    send_cmd(make_cmd(CMD_FIT, 0, 0, 0, 32'sh10000, 0, 0));
    send_cmd(make_cmd(CMD_FIT, 0, 0, 32'sh10000, -1, 0, 0));
    send_cmd(make_cmd(CMD_FIT, 0, 0, 32'sh10000, 32'sh10000, -1, 0));
    send_cmd(make_cmd(CMD_FIT, 0, 0, 32'sh10000, 32'sh10000, 32'sh8000, 0));
    send_cmd(make_cmd(CMD_FIT, 0, 0, 32'sh10000, 32'sh10000, 32'sh7FFFFFFF, 0));
    send_cmd(make_cmd(CMD_FIT, 5, 7, 1, 1, 0, 0));
    send_cmd(make_cmd(CMD_FIT, 5, 7, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0));
    send_cmd(make_cmd(CMD_BAD6, -1, -1, -1, -1, -1, 20'hFFFFF));
    send_cmd(make_cmd(CMD_BAD7, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_VIS, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_default_view;
    run_random(450, 0, 0);
  endtask

  task automatic test_large_canvas;
    set_view_regs(32'd1920 << 16, 32'd1080 << 16, 20'd1, 20'hFFFFF);
    run_random(450, 65, 0);
  endtask

  task automatic test_crossed_limits;
    // min above max: requests below min give min, all others give max
    set_view_regs(32'hFFFFFFFF, 32'd1, 20'h30000, 20'h08000);
    run_random(450, 0, 65);
  endtask

  task automatic test_extreme_canvas;
    set_view_regs(32'd1, 32'hFFFFFFFF, 20'hFFFFF, 20'hFFFFF);
    run_random(150, 36, 36);
    set_view_regs(32'd640 << 16, 32'd480 << 16, 20'd6554, 20'd524288);
    run_random(300, 36, 36);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.rect_width = '0;
    in_ch.rect_height = '0;
    in_ch.padding = '0;
    in_ch.zoom_request = '0;
    out_ch.ready = 1'b0;
    view_origin_x = 0;
    view_origin_y = 0;
    view_zoom = 64'd65536;
    view_rev = 32'd1;
    canvas_w = 64'd65536;
    canvas_h = 64'd65536;
    zoom_lo = 64'd6554;
    zoom_hi = 64'd524288;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_default_view();
    test_large_canvas();
    test_crossed_limits();
    test_extreme_canvas();
    drain();
    repeat (250) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
